// ----- hw/rtl/ipbm_pkg.sv -----
// shared types and constants for the icon pixel to bitmap/mask converter
// no dependencies; used by all ipbm modules and the core top level
package ipbm_pkg;

  localparam int unsigned DimW       = 9;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 9;
  localparam int unsigned ColorAddrW = 18;
  localparam int unsigned MaskAddrW  = 13;
  localparam int unsigned DimMax     = (1 << DimW) - 1;
  localparam int unsigned DefMaxSide = 256;

  localparam logic [DimW-1:0] ResetWidth  = DimW'(32);
  localparam logic [DimW-1:0] ResetHeight = DimW'(32);

  localparam int unsigned InTdataW  = 32;
  localparam int unsigned ResultW   = ColorAddrW + 32 + MaskAddrW + 3 + 1;
  localparam int unsigned OutTdataW = ((ResultW + 7) / 8) * 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_ALPHA_MODE   = 2'd2,
    REG_SRC_ALPHA    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic            alpha_mode;
    logic            source_has_alpha;
  } cfg_t;

  // red in the lowest byte
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // color_address in the lowest bits
  typedef struct packed {
    logic                  mask_flag;
    logic [2:0]            mask_pos;
    logic [MaskAddrW-1:0]  mask_address;
    logic [31:0]           color_data;
    logic [ColorAddrW-1:0] color_address;
  } result_t;

endpackage

// ----- hw/rtl/ipbm_cfg.sv -----
// configuration registers, clamped image size and pixel position counters
// depends on ipbm_pkg
module ipbm_cfg #(
  parameter int unsigned MAX_SIDE = ipbm_pkg::DefMaxSide,
  parameter int unsigned CNT_W    = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ipbm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ipbm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          advance_i,
  output ipbm_pkg::cfg_t                cfg_o,
  output logic [CNT_W-1:0]              col_cnt_o,
  output logic [CNT_W-1:0]              row_cnt_o,
  output logic                          last_o
);

  localparam int unsigned SideCap = (MAX_SIDE < ipbm_pkg::DimMax) ? MAX_SIDE
                                                                  : ipbm_pkg::DimMax;
  localparam int unsigned CmpW    = (CNT_W > ipbm_pkg::DimW) ? CNT_W : ipbm_pkg::DimW;

  logic [ipbm_pkg::DimW-1:0] width_q, width_d, height_q, height_d;
  logic                      alpha_mode_q, alpha_mode_d, src_alpha_q, src_alpha_d;
  logic [CNT_W-1:0]          col_q, col_d, row_q, row_d;
  logic [ipbm_pkg::DimW-1:0] w_clamp, h_clamp;
  logic                      col_end, row_end;

  function automatic logic [ipbm_pkg::DimW-1:0] clamp_side(
    input logic [ipbm_pkg::DimW-1:0] v
  );
    logic [ipbm_pkg::DimW-1:0] res;
    if (v == '0) begin
      res = ipbm_pkg::DimW'(1);
    end else if (32'(v) > SideCap) begin
      res = ipbm_pkg::DimW'(SideCap);
    end else begin
      res = v;
    end
    return res;
  endfunction

  assign w_clamp = clamp_side(width_q);
  assign h_clamp = clamp_side(height_q);
  assign col_end = (CmpW'(col_q) == CmpW'(w_clamp - ipbm_pkg::DimW'(1)));
  assign row_end = (CmpW'(row_q) == CmpW'(h_clamp - ipbm_pkg::DimW'(1)));

  always_comb begin
    width_d      = width_q;
    height_d     = height_q;
    alpha_mode_d = alpha_mode_q;
    src_alpha_d  = src_alpha_q;
    col_d        = col_q;
    row_d        = row_q;
    if (advance_i) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
    if (cfg_we_i) begin
      case (ipbm_pkg::cfg_reg_e'(cfg_index_i))
        ipbm_pkg::REG_IMAGE_WIDTH: begin
          width_d = cfg_data_i;
          col_d   = '0;
          row_d   = '0;
        end
        ipbm_pkg::REG_IMAGE_HEIGHT: begin
          height_d = cfg_data_i;
          col_d    = '0;
          row_d    = '0;
        end
        ipbm_pkg::REG_ALPHA_MODE: alpha_mode_d = cfg_data_i[0];
        ipbm_pkg::REG_SRC_ALPHA:  src_alpha_d  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= ipbm_pkg::ResetWidth;
      height_q     <= ipbm_pkg::ResetHeight;
      alpha_mode_q <= 1'b1;
      src_alpha_q  <= 1'b1;
      col_q        <= '0;
      row_q        <= '0;
    end else begin
      width_q      <= width_d;
      height_q     <= height_d;
      alpha_mode_q <= alpha_mode_d;
      src_alpha_q  <= src_alpha_d;
      col_q        <= col_d;
      row_q        <= row_d;
    end
  end

  assign cfg_o.width            = w_clamp;
  assign cfg_o.height           = h_clamp;
  assign cfg_o.alpha_mode       = alpha_mode_q;
  assign cfg_o.source_has_alpha = src_alpha_q;
  assign col_cnt_o              = col_q;
  assign row_cnt_o              = row_q;
  assign last_o                 = col_end && row_end;

endmodule

// ----- hw/rtl/ipbm_calc.sv -----
// per-pixel datapath: centering, color and mask addresses, swizzle, mask bit
// depends on ipbm_pkg
module ipbm_calc #(
  parameter int unsigned CNT_W = 8
) (
  input  ipbm_pkg::cfg_t    cfg_i,
  input  ipbm_pkg::pixel_t  pix_i,
  input  logic [CNT_W-1:0]  col_cnt_i,
  input  logic [CNT_W-1:0]  row_cnt_i,
  output ipbm_pkg::result_t res_o
);

  localparam int unsigned AW = ipbm_pkg::ColorAddrW;
  localparam int unsigned DW = ipbm_pkg::DimW;

  logic          wide;
  logic [DW-1:0] side, diff, half;
  logic [AW-1:0] col, row, mstride, stride24, pitch, col_off, prod, caddr, mprod, maddr;
  logic [DW:0]   msum;
  logic [DW+2:0] s3;
  logic          transp;

  always_comb begin
    wide     = cfg_i.width > cfg_i.height;
    side     = wide ? cfg_i.width : cfg_i.height;
    diff     = wide ? cfg_i.width - cfg_i.height : cfg_i.height - cfg_i.width;
    half     = diff >> 1;
    col      = AW'(col_cnt_i) + (wide ? '0 : AW'(half));
    row      = AW'(row_cnt_i) + (wide ? AW'(half) : '0);
    msum     = {1'b0, side} + (DW+1)'(31);
    mstride  = AW'(msum[DW:5]) << 2;
    s3       = (DW+3)'(side) + ((DW+3)'(side) << 1) + (DW+3)'(3);
    stride24 = AW'({s3[DW+2:2], 2'b00});
    pitch    = cfg_i.alpha_mode ? (AW'(side) << 2) : stride24;
    col_off  = cfg_i.alpha_mode ? (col << 2) : (col + (col << 1));
    prod     = row * pitch;
    caddr    = prod + col_off;
    mprod    = row * mstride;
    maddr    = mprod + (col >> 3);
    transp   = cfg_i.source_has_alpha && !pix_i.alpha[7];

    res_o.color_address = caddr;
    res_o.mask_address  = maddr[ipbm_pkg::MaskAddrW-1:0];
    res_o.mask_pos      = 3'd7 - col[2:0];
    if (cfg_i.alpha_mode) begin
      res_o.color_data = {pix_i.alpha, pix_i.red, pix_i.green, pix_i.blue};
      res_o.mask_flag  = (pix_i.alpha == 8'd0);
    end else begin
      res_o.color_data = transp ? 32'd0 : {8'd0, pix_i.red, pix_i.green, pix_i.blue};
      res_o.mask_flag  = transp;
    end
  end

endmodule

// ----- hw/rtl/icon_pixel_to_bitmap_mask_core.sv -----
// icon pixel to bitmap/mask converter, top level
// one pixel beat in on the s_axis side gives one color and mask write beat on m_axis;
// configuration over a plain write port (width, height, alpha mode, source alpha).
// pixels arrive in loop order, bottom-up rows; the image is centered in a square
// bitmap whose side is the larger dimension. each output beat carries the color
// byte address and data and the mask byte address, bit index and bit; tlast marks
// the final pixel of the image.
// an input beat passes an input register and then a result register, with the address
// arithmetic (one multiply per address) between them.
// throughput is one pixel per cycle; s_axis_tready drops only when both stages are
// full and m_axis_tready is low, and a held result keeps its beat stable.
// reset clears the stage valids, the pixel counters and restores the register
// defaults (32 x 32, alpha mode, source alpha). writing width or height restarts
// the image at the first pixel.
// depends on ipbm_pkg, ipbm_cfg, ipbm_calc
module icon_pixel_to_bitmap_mask_core #(
  parameter int unsigned MAX_SIDE = ipbm_pkg::DefMaxSide
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ipbm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ipbm_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // red, green, blue, alpha
  input  logic [ipbm_pkg::InTdataW-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // color_address, color_data, mask_address, mask_pos, mask_flag, zero fill
  output logic [ipbm_pkg::OutTdataW-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast
);

  localparam int unsigned CNT_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  ipbm_pkg::cfg_t    cfg;
  ipbm_pkg::pixel_t  pix_q;
  ipbm_pkg::result_t res, res_q;
  logic [CNT_W-1:0]  col_cnt, row_cnt, col_q, row_q;
  logic              cnt_last, last_q, out_last_q;
  logic              s1_valid_q, s1_valid_d, out_valid_q, out_valid_d;
  logic              in_acc, s1_move;

  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  ipbm_cfg #(
    .MAX_SIDE (MAX_SIDE),
    .CNT_W    (CNT_W)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (in_acc),
    .cfg_o       (cfg),
    .col_cnt_o   (col_cnt),
    .row_cnt_o   (row_cnt),
    .last_o      (cnt_last)
  );

  ipbm_calc #(
    .CNT_W (CNT_W)
  ) u_calc (
    .cfg_i     (cfg),
    .pix_i     (pix_q),
    .col_cnt_i (col_q),
    .row_cnt_i (row_q),
    .res_o     (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q  <= ipbm_pkg::pixel_t'(s_axis_tdata);
      col_q  <= col_cnt;
      row_q  <= row_cnt;
      last_q <= cnt_last;
    end
    if (s1_move) begin
      res_q      <= res;
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ipbm_pkg::OutTdataW'(res_q);
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- verif/ipbm_write_checker.sv -----
// checker for the icon pixel to bitmap/mask core: follows the register writes and pixel beats,
// predicts each color/mask write beat and compares it with what leaves m_axis
// depends on ipbm_pkg
module ipbm_write_checker
  import ipbm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  // red, green, blue, alpha
  input  logic [InTdataW-1:0]   s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // color_address, color_data, mask_address, mask_pos, mask_flag, zero fill
  input  logic [OutTdataW-1:0]  m_axis_tdata,
  input  logic                  m_axis_tlast,
  output int unsigned           mismatch_count,
  output int unsigned           outstanding,
  output int unsigned           checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    result_t fields;
    logic    last;
  } pixel_write_t;

  logic [DimW-1:0] width_q;
  logic [DimW-1:0] height_q;
  logic            alpha_mode_q;
  logic            src_alpha_q;
  logic [7:0]      col_q;
  logic [7:0]      row_q;
  pixel_write_t    pending_writes[$];

  function automatic int unsigned clamp_dim(logic [DimW-1:0] v);
    if (v == '0) return 1;
    if (v > DefMaxSide) return DefMaxSide;
    return v;
  endfunction

  function automatic pixel_write_t convert_pixel(pixel_t p);
    int unsigned w, h, c, r, side, x_off, y_off, col, row, mask_stride, stride;
    pixel_write_t e;
    w = clamp_dim(width_q);
    h = clamp_dim(height_q);
    c = col_q;
    r = row_q;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    if (w > h) begin
      side  = w;
      x_off = 0;
      y_off = (w - h) / 2;
    end else begin
      side  = h;
      x_off = (h - w) / 2;
      y_off = 0;
    end
    col = c + x_off;
    row = r + y_off;
    mask_stride = ((side + 31) & ~32'd31) >> 3;
    if (alpha_mode_q) begin
      e.fields.color_address = ColorAddrW'(4 * (row * side + col));
      e.fields.color_data    = {p.alpha, p.red, p.green, p.blue};
      e.fields.mask_flag     = (p.alpha == 8'd0);
    end else begin
      stride = (3 * side + 3) & ~32'd3;
      e.fields.color_address = ColorAddrW'(row * stride + 3 * col);
      if (src_alpha_q && p.alpha < 8'd128) begin
        e.fields.color_data = '0;
        e.fields.mask_flag  = 1'b1;
      end else begin
        e.fields.color_data = {8'd0, p.red, p.green, p.blue};
        e.fields.mask_flag  = 1'b0;
      end
    end
    e.fields.mask_address = MaskAddrW'(row * mask_stride + (col >> 3));
    e.fields.mask_pos     = 3'(7 - (col & 7));
    e.last = (c + 1 >= w) && (r + 1 >= h);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_q = 8'(c);
    row_q = 8'(r);
    return e;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] seen);
    if (want !== seen) begin
      mismatch_count++;
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, seen);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_write_t want;
    result_t      got;
    if (!rst_ni) begin
      width_q        = ResetWidth;
      height_q       = ResetHeight;
      alpha_mode_q   = 1'b1;
      src_alpha_q    = 1'b1;
      col_q          = '0;
      row_q          = '0;
      mismatch_count = 0;
      checked_count  = 0;
      outstanding    = 0;
      pending_writes.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[ResultW-1:0]);
        if (pending_writes.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected beat expected none actual tdata 0x%0h tlast %0b",
                   $time, m_axis_tdata, m_axis_tlast);
        end else begin
          want = pending_writes.pop_front();
          checked_count++;
          check_field("color_address", 64'(want.fields.color_address),
                      64'(got.color_address));
          check_field("color_data", 64'(want.fields.color_data), 64'(got.color_data));
          check_field("mask_address", 64'(want.fields.mask_address),
                      64'(got.mask_address));
          check_field("mask_pos", 64'(want.fields.mask_pos), 64'(got.mask_pos));
          check_field("mask_flag", 64'(want.fields.mask_flag), 64'(got.mask_flag));
          check_field("tlast", 64'(want.last), 64'(m_axis_tlast));
          check_field("zero fill", '0, 64'(m_axis_tdata >> ResultW));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_writes.push_back(convert_pixel(pixel_t'(s_axis_tdata)));
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_IMAGE_WIDTH: begin
            width_q = cfg_data_i[DimW-1:0];
            col_q   = '0;
            row_q   = '0;
          end
          REG_IMAGE_HEIGHT: begin
            height_q = cfg_data_i[DimW-1:0];
            col_q    = '0;
            row_q    = '0;
          end
          REG_ALPHA_MODE: alpha_mode_q = cfg_data_i[0];
          REG_SRC_ALPHA:  src_alpha_q  = cfg_data_i[0];
          default: ;
        endcase
      end
      outstanding = pending_writes.size();
    end
  end

endmodule

// ----- verif/tb_top.sv -----
// top of the icon pixel to bitmap/mask testbench: clock, reset, register writes,
// pixel stimulus with bursts and gaps, a stalling receiver, and the verdict
// depends on ipbm_pkg, icon_pixel_to_bitmap_mask_core and ipbm_write_checker
module tb_top;
  import ipbm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 400;
  localparam int unsigned HoldCycles  = 64;
  localparam int unsigned CycleLimit  = 200000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_index_i;
  logic [CfgDataW-1:0]  cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned checked_count;

  pixel_t          pixel_q[$];
  int unsigned     burst_left;
  int unsigned     sent_count;
  int unsigned     hold_count;
  bit              hold_req;
  logic [DimW-1:0] cur_w;
  logic [DimW-1:0] cur_h;

  icon_pixel_to_bitmap_mask_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  ipbm_write_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .checked_count  (checked_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic cfg_write(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    if (idx == REG_IMAGE_WIDTH) cur_w = val;
    if (idx == REG_IMAGE_HEIGHT) cur_h = val;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (outstanding != 0);
    @(posedge clk_i);
  endtask

  task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    pixel_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.alpha = a;
    pixel_q.push_back(p);
  endtask

  task automatic feed_pixels();
    int unsigned gap;
    bit rdy;
    while (pixel_q.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= pixel_q.pop_front();
      do begin
        @(negedge clk_i);
        rdy = s_axis_tready;
        @(posedge clk_i);
      end while (!rdy);
      burst_left--;
      sent_count++;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [DimW-1:0] pick_side();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return DimW'(DefMaxSide);
      2:       return DimW'($urandom_range(DefMaxSide + 1, DimMax));
      3:       return DimW'($urandom_range(100, DefMaxSide - 1));
      4, 5, 6: return DimW'($urandom_range(9, 40));
      default: return DimW'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic int unsigned side_of(logic [DimW-1:0] v);
    return (v == '0) ? 1 : ((v > DefMaxSide) ? DefMaxSide : v);
  endfunction

  function automatic logic [CfgDataW-1:0] mode_value();
    return CfgDataW'($urandom);
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p = pixel_t'($urandom);
    case ($urandom_range(0, 9))
      0:       p.alpha = 8'd0;
      1:       p.alpha = 8'd127;
      2:       p.alpha = 8'd128;
      3:       p.alpha = 8'd255;
      default: ;
    endcase
    return p;
  endfunction

  // receiver: ready patterns that change every so often, plus long hold-offs on request
  initial begin
    int unsigned ready_mode;
    int unsigned mode_left;
    mode_left = 0;
    ready_mode = 0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_count++;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(16, 160);
        end
        mode_left--;
        case (ready_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycles, outstanding);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned phase_count;
    int unsigned area;
    int unsigned n;
    int unsigned split;
    int unsigned target;
    bit held_once;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    hold_req      = 1'b0;
    burst_left    = 0;
    sent_count    = 0;
    hold_count    = 0;
    phase_count   = 0;
    held_once     = 1'b0;
    cur_w         = ResetWidth;
    cur_h         = ResetHeight;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry and modes, field extremes
    add_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    add_pixel(8'hff, 8'hff, 8'hff, 8'hff);
    add_pixel(8'h12, 8'h34, 8'h56, 8'h01);
    add_pixel(8'hab, 8'hcd, 8'hef, 8'h80);
    feed_pixels();
    wait_drained();

    // zero sides act as one
    cfg_write(REG_IMAGE_WIDTH, '0);
    cfg_write(REG_IMAGE_HEIGHT, '0);
    add_pixel(8'h11, 8'h22, 8'h33, 8'h00);
    add_pixel(8'h44, 8'h55, 8'h66, 8'hff);
    feed_pixels();
    wait_drained();

    // oversized width saturates, 24-bit output
    cfg_write(REG_IMAGE_WIDTH, DimW'(DimMax));
    cfg_write(REG_IMAGE_HEIGHT, DimW'(1));
    cfg_write(REG_ALPHA_MODE, '0);
    add_pixel(8'h80, 8'h7f, 8'h01, 8'd127);
    add_pixel(8'hfe, 8'h02, 8'h40, 8'd128);
    feed_pixels();
    wait_drained();

    cfg_write(REG_IMAGE_WIDTH, DimW'(1));
    cfg_write(REG_IMAGE_HEIGHT, DimW'(300));
    add_pixel(8'h5a, 8'ha5, 8'hc3, 8'h3c);
    feed_pixels();
    wait_drained();

    // mode change in the middle of an image keeps the position
    cfg_write(REG_IMAGE_WIDTH, DimW'(3));
    cfg_write(REG_IMAGE_HEIGHT, DimW'(2));
    cfg_write(REG_SRC_ALPHA, 9'h001);
    add_pixel(8'h10, 8'h20, 8'h30, 8'd0);
    add_pixel(8'h40, 8'h50, 8'h60, 8'd127);
    add_pixel(8'h70, 8'h80, 8'h90, 8'd128);
    feed_pixels();
    wait_drained();
    cfg_write(REG_ALPHA_MODE, 9'h1ff);
    add_pixel(8'ha0, 8'hb0, 8'hc0, 8'd255);
    add_pixel(8'hd0, 8'he0, 8'hf0, 8'd0);
    add_pixel(8'h01, 8'h02, 8'h03, 8'd64);
    feed_pixels();
    wait_drained();

    // source alpha off
    cfg_write(REG_ALPHA_MODE, 9'h1fe);
    cfg_write(REG_SRC_ALPHA, 9'h1fe);
    cfg_write(REG_IMAGE_WIDTH, DimW'(2));
    cfg_write(REG_IMAGE_HEIGHT, DimW'(1));
    add_pixel(8'hff, 8'h00, 8'hff, 8'd0);
    add_pixel(8'h00, 8'hff, 8'h00, 8'd255);
    feed_pixels();

    target = sent_count + RandomItems;
    while (sent_count < target) begin
      phase_count++;
      wait_drained();
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 1) == 1) begin
          cfg_write(REG_IMAGE_WIDTH, pick_side());
          cfg_write(REG_IMAGE_HEIGHT, pick_side());
        end else begin
          cfg_write(REG_IMAGE_HEIGHT, pick_side());
          cfg_write(REG_IMAGE_WIDTH, pick_side());
        end
      end
      if ($urandom_range(0, 1) == 1) cfg_write(REG_ALPHA_MODE, mode_value());
      if ($urandom_range(0, 1) == 1) cfg_write(REG_SRC_ALPHA, mode_value());
      area = side_of(cur_w) * side_of(cur_h);
      if (area <= 96) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, area)
                                        : area * $urandom_range(1, 2);
      end else begin
        n = $urandom_range(4, 40);
      end
      if (n > target - sent_count) n = target - sent_count;
      if (!held_once && n < 8) n = 8;
      if (n >= 8 && (!held_once || $urandom_range(0, 7) == 0)) begin
        hold_req  = 1'b1;
        held_once = 1'b1;
      end
      split = (n >= 2 && $urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : 0;
      for (int unsigned i = 0; i < n; i++) begin
        if (split != 0 && i == split) begin
          feed_pixels();
          wait_drained();
          cfg_write(REG_ALPHA_MODE, mode_value());
          cfg_write(REG_SRC_ALPHA, mode_value());
        end
        pixel_q.push_back(random_pixel());
      end
      feed_pixels();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    $display("%0d pixel beats over %0d random phases, %0d write beats checked",
             sent_count, phase_count, checked_count);
    $display("%0d long receiver hold-offs; clamped sides, both output modes, mid-image mode changes",
             hold_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d write beats never arrived", mismatch_count, outstanding);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ipbm_pkg.sv
hw/rtl/ipbm_cfg.sv
hw/rtl/ipbm_calc.sv
hw/rtl/icon_pixel_to_bitmap_mask_core.sv
verif/ipbm_write_checker.sv
verif/tb_top.sv
